[design/png_metadata_chunk_filter_unit_assert.svh]
// Assertion macros for the PNG metadata chunk filter.
// No dependencies; included by the top level only.
`ifndef PNG_METADATA_CHUNK_FILTER_UNIT_ASSERT_SVH
`define PNG_METADATA_CHUNK_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define PMCF_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pmcf assertion failed");
// Next-cycle implication
`define PMCF_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pmcf assertion failed");
`else
`define PMCF_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define PMCF_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

[design/pmcf_pkg.sv]
// Package for the PNG metadata chunk filter: walk phases, result burst type,
// PNG signature and chunk type constants. No dependencies.
package pmcf_pkg;

  // Walk phase of the chunk parser
  typedef enum logic [1:0] {
    PH_SIG  = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } walk_phase_t;

  // Report status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_NOTPNG = 1'b1;

  // Signature bytes, entry 0 comes first in the file
  localparam logic [7:0][7:0] PNG_SIG = {
    8'h0A, 8'h1A, 8'h0A, 8'h0D, 8'h47, 8'h4E, 8'h50, 8'h89
  };

  localparam logic [31:0] SIG_LEN     = 32'd8;
  localparam logic [32:0] CHUNK_OVHD  = 33'd12;  // length + type + CRC
  localparam logic [32:0] CRC_LEN     = 33'd4;
  localparam logic [3:0]  BURST_FULL  = 4'd8;
  localparam logic [3:0]  BURST_ONE   = 4'd1;
  localparam logic [3:0]  BURST_NONE  = 4'd0;

  // Chunk type codes, first type byte in the top bits
  localparam logic [31:0] TYPE_EXIF = 32'h6558_4966;
  localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
  localparam logic [31:0] TYPE_ITXT = 32'h6954_5874;
  localparam logic [31:0] TYPE_ZTXT = 32'h7A54_5874;
  localparam logic [31:0] TYPE_TIME = 32'h7449_4D45;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // Results caused by one input word: up to eight bytes, then maybe a report
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      byte_cnt;
    logic            report;
    logic            rpt_status;
  } burst_t;

  function automatic logic is_meta(input logic [31:0] ctype);
    is_meta = (ctype == TYPE_EXIF) || (ctype == TYPE_TEXT) ||
              (ctype == TYPE_ITXT) || (ctype == TYPE_ZTXT) ||
              (ctype == TYPE_TIME);
  endfunction

endpackage

[design/png_metadata_chunk_filter_unit.sv]
// Top level of the PNG metadata chunk filter: walker plus result sequencer.
// Depends on pmcf_pkg, pmcf_walk, pmcf_emit and the assertion header.
//
// Usage: write the file length on the cfg channel (cfg_data, always ready)
// while idle, then stream the file one byte per word on the in channel.
// The out channel carries kept bytes (item_kind 0) and, once per file, a
// report word (item_kind 1) with status, removed_chunks and removed_bytes.
// run_last marks the last word caused by one input byte.
// Latency: results of a byte appear on out the cycle after it is accepted.
// Throughput: one input byte per cycle while out_ready is high and each byte
// yields at most one word; a byte that yields more than one word holds in_ready
// low until its last word is taken, since the sequencer sends one word per cycle
// while out_ready is high (up to 9 after the signature, 8 when a kept header completes).
// Stalls: while out_ready is low the pending word holds and in_ready stays
// low once the burst register is occupied.
// Reset: synchronous, clears the walk to the signature phase, the counters
// and the file length; after the report, further bytes are accepted and
// swallowed until the next reset.
`include "png_metadata_chunk_filter_unit_assert.svh"

module png_metadata_chunk_filter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [7:0]  out_byte,
  output logic        status,
  output logic [31:0] removed_chunks,
  output logic [31:0] removed_bytes,
  output logic        run_last
);
  import pmcf_pkg::*;

  logic        accept;
  logic        load;
  burst_t      burst;
  logic [31:0] drop_cnt;
  logic [31:0] drop_bytes;
  logic        is_report;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  pmcf_walk u_walk (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .in_byte        (in_byte),
    .load           (load),
    .burst          (burst),
    .dropped_chunks (drop_cnt),
    .dropped_bytes  (drop_bytes)
  );

  pmcf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .burst_in   (burst),
    .free       (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_report  (is_report),
    .byte_out   (out_byte),
    .rpt_status (status),
    .last       (run_last)
  );

  // Counters are frozen once the report is due, so they are read live
  assign item_kind      = is_report;
  assign removed_chunks = is_report ? drop_cnt : 32'd0;
  assign removed_bytes  = is_report ? drop_bytes : 32'd0;

  // Checks
  `PMCF_ASSERT_IMP(a_idle_ready, clk, rst, !out_valid, in_ready)
  `PMCF_ASSERT_IMP(a_report_last, clk, rst, out_valid && item_kind, run_last)
  `PMCF_ASSERT_NXT(a_report_final, clk, rst, out_valid && out_ready && item_kind, !out_valid)

endmodule

[design/pmcf_walk.sv]
// Chunk walker: file length register, signature check, header capture,
// keep/drop decision and drop counters. Depends on pmcf_pkg.
module pmcf_walk (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_data,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  output logic                 load,
  output pmcf_pkg::burst_t     burst,
  output logic [31:0]          dropped_chunks,
  output logic [31:0]          dropped_bytes
);
  import pmcf_pkg::*;

  logic [31:0] file_length;
  walk_phase_t phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [7:0]  hdr [7];
  logic [32:0] start12, start12_next;     // chunk start + 12
  logic [32:0] body_left, body_left_next; // data + CRC bytes still to come
  logic        kept, kept_next;
  logic        is_end, is_end_next;
  logic [31:0] drop_cnt, drop_cnt_next;
  logic [31:0] drop_bytes, drop_bytes_next;

  logic [31:0] pos_inc;
  logic [32:0] bnd_sum;
  logic        bnd_short;
  logic [31:0] len;
  logic [31:0] ctype;
  logic [33:0] ovr_sum;
  logic        overrun;

  // Boundary and overrun arithmetic
  assign pos_inc   = pos + 32'd1;
  assign bnd_sum   = {1'b0, pos_inc} + CHUNK_OVHD;
  assign bnd_short = bnd_sum > {1'b0, file_length};
  assign len       = {hdr[0], hdr[1], hdr[2], hdr[3]};
  assign ctype     = {hdr[4], hdr[5], hdr[6], in_byte};
  assign ovr_sum   = {1'b0, start12} + {2'b00, len};
  assign overrun   = ovr_sum > {2'b00, file_length};

  // Next state and result burst
  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    hdr_cnt_next    = hdr_cnt;
    start12_next    = start12;
    body_left_next  = body_left;
    kept_next       = kept;
    is_end_next     = is_end;
    drop_cnt_next   = drop_cnt;
    drop_bytes_next = drop_bytes;
    burst           = '0;
    if (accept) begin
      unique case (phase)
        PH_SIG: begin
          if (file_length < SIG_LEN || in_byte != PNG_SIG[pos[2:0]]) begin
            burst.report     = 1'b1;
            burst.rpt_status = ST_NOTPNG;
            phase_next       = PH_DONE;
          end else begin
            pos_next = pos_inc;
            if (pos_inc == SIG_LEN) begin
              burst.bytes    = PNG_SIG;
              burst.byte_cnt = BURST_FULL;
              if (bnd_short) begin
                burst.report = 1'b1;
                phase_next   = PH_DONE;
              end else begin
                phase_next   = PH_HDR;
                hdr_cnt_next = '0;
                start12_next = bnd_sum;
              end
            end
          end
        end
        PH_HDR: begin
          pos_next     = pos_inc;
          hdr_cnt_next = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd7) begin
            if (overrun) begin
              burst.report = 1'b1;
              phase_next   = PH_DONE;
            end else begin
              kept_next   = !is_meta(ctype);
              is_end_next = (ctype == TYPE_IEND);
              if (!is_meta(ctype)) begin
                burst.bytes    = {in_byte, hdr[6], hdr[5], hdr[4],
                                  hdr[3], hdr[2], hdr[1], hdr[0]};
                burst.byte_cnt = BURST_FULL;
              end else begin
                drop_cnt_next   = drop_cnt + 32'd1;
                drop_bytes_next = drop_bytes + len + 32'd12;
              end
              body_left_next = {1'b0, len} + CRC_LEN;
              phase_next     = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (kept) begin
            burst.bytes[0] = in_byte;
            burst.byte_cnt = BURST_ONE;
          end
          pos_next       = pos_inc;
          body_left_next = body_left - 33'd1;
          if (body_left == 33'd1) begin
            if (is_end || bnd_short) begin
              burst.report = 1'b1;
              phase_next   = PH_DONE;
            end else begin
              phase_next   = PH_HDR;
              hdr_cnt_next = '0;
              start12_next = bnd_sum;
            end
          end
        end
        PH_DONE: begin
          // trailing bytes are swallowed
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  assign load = (burst.byte_cnt != BURST_NONE) || burst.report;
  assign dropped_chunks = drop_cnt;
  assign dropped_bytes  = drop_bytes;

  // Control and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
      phase       <= PH_SIG;
      pos         <= '0;
      hdr_cnt     <= '0;
      start12     <= '0;
      body_left   <= '0;
      kept        <= 1'b0;
      is_end      <= 1'b0;
      drop_cnt    <= '0;
      drop_bytes  <= '0;
    end else begin
      if (cfg_we) begin
        file_length <= cfg_data;
      end
      phase      <= phase_next;
      pos        <= pos_next;
      hdr_cnt    <= hdr_cnt_next;
      start12    <= start12_next;
      body_left  <= body_left_next;
      kept       <= kept_next;
      is_end     <= is_end_next;
      drop_cnt   <= drop_cnt_next;
      drop_bytes <= drop_bytes_next;
    end
  end

  // Header bytes, last one used straight from the input
  always_ff @(posedge clk) begin
    if (accept && phase == PH_HDR && hdr_cnt != 3'd7) begin
      hdr[hdr_cnt] <= in_byte;
    end
  end

endmodule

[design/pmcf_emit.sv]
// Result sequencer: holds one burst and plays it out one word per cycle while out_ready is high.
// Depends on pmcf_pkg.
module pmcf_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  pmcf_pkg::burst_t burst_in,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             is_report,
  output logic [7:0]       byte_out,
  output logic             rpt_status,
  output logic             last
);
  import pmcf_pkg::*;

  logic       busy;
  logic [3:0] idx;
  burst_t     cur;
  logic       is_byte;
  logic       pop_last;

  // Current word decode
  assign is_byte    = idx < cur.byte_cnt;
  assign is_report  = !is_byte;
  assign byte_out   = is_byte ? cur.bytes[idx[2:0]] : 8'h00;
  assign rpt_status = is_byte ? 1'b0 : cur.rpt_status;
  assign last       = is_byte ? ((idx == cur.byte_cnt - 4'd1) && !cur.report) : 1'b1;
  assign out_valid  = busy;
  assign pop_last   = busy && out_ready && last;
  assign free       = !busy || pop_last;

  // Burst register and word index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (pop_last) begin
      busy <= 1'b0;
    end else if (busy && out_ready) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= burst_in;
    end
  end

endmodule

[test/png_chunk_filter_scoreboard_pkg.sv]
// Scoreboard for the PNG metadata chunk filter: predicts the cleaned byte
// stream and the final report word, then checks every output word in order.
// Depends on pmcf_pkg for the walk phases, status codes and chunk types.
`timescale 1ns / 100ps

package png_chunk_filter_scoreboard_pkg;
  import pmcf_pkg::*;

  // One output word, fields in port order
  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_val;
    logic        stat;
    logic [31:0] rm_chunks;
    logic [31:0] rm_bytes;
    logic        run_end;
  } result_word_t;

  class chunk_filter_scoreboard;
    logic [31:0]  file_len;
    logic [31:0]  pos;
    walk_phase_t  phase;
    logic [7:0]   hold [8];
    logic [32:0]  left;
    logic         keep_chunk;
    logic         end_chunk;
    logic [31:0]  drop_chunks;
    logic [31:0]  drop_bytes;
    result_word_t expected_words [$];
    int           mismatches;
    int           checked;

    function new();
      file_len    = '0;
      pos         = '0;
      phase       = PH_SIG;
      left        = '0;
      keep_chunk  = 1'b0;
      end_chunk   = 1'b0;
      drop_chunks = '0;
      drop_bytes  = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void set_length(logic [31:0] v);
      file_len = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void push_byte(logic [7:0] b);
      expected_words.push_back(result_word_t'{kind: 1'b0, byte_val: b, stat: 1'b0,
                                              rm_chunks: 32'd0, rm_bytes: 32'd0,
                                              run_end: 1'b0});
    endfunction

    // Report word; the walk is over after it
    function void push_report(logic st);
      expected_words.push_back(result_word_t'{kind: 1'b1, byte_val: 8'd0, stat: st,
                                              rm_chunks: drop_chunks,
                                              rm_bytes: drop_bytes, run_end: 1'b0});
      phase = PH_DONE;
    endfunction

    function bit is_removed_type(logic [31:0] t);
      return t == TYPE_EXIF || t == TYPE_TEXT || t == TYPE_ITXT ||
             t == TYPE_ZTXT || t == TYPE_TIME;
    endfunction

    // Chunk boundary: stop when a minimal chunk no longer fits
    function void chunk_boundary();
      if ({32'd0, pos} + 64'd12 > {32'd0, file_len}) begin
        push_report(ST_OK);
      end else begin
        phase = PH_HDR;
        left  = 33'd8;
      end
    endfunction

    // Accepted input byte: queue the words it causes
    function void note_byte(logic [7:0] b);
      int          first;
      int          i;
      logic [63:0] len;
      logic [63:0] start;
      logic [31:0] ctype;
      first = expected_words.size();
      case (phase)
        PH_SIG: begin
          if (file_len < 32'd8 || b != PNG_SIG[pos[2:0]]) begin
            push_report(ST_NOTPNG);
          end else begin
            pos = pos + 32'd1;
            if (pos >= 32'd8) begin
              for (i = 0; i < 8; i++) push_byte(PNG_SIG[i]);
              chunk_boundary();
            end
          end
        end
        PH_HDR: begin
          hold[8 - int'(left[3:0])] = b;
          pos  = pos + 32'd1;
          left = left - 33'd1;
          if (left == 33'd0) begin
            len   = {32'd0, hold[0], hold[1], hold[2], hold[3]};
            ctype = {hold[4], hold[5], hold[6], hold[7]};
            start = {32'd0, pos} - 64'd8;
            // header held back when the chunk would run past the file end
            if (start + 64'd12 + len > {32'd0, file_len}) begin
              push_report(ST_OK);
            end else begin
              keep_chunk = !is_removed_type(ctype);
              end_chunk  = (ctype == TYPE_IEND);
              if (keep_chunk) begin
                for (i = 0; i < 8; i++) push_byte(hold[i]);
              end else begin
                drop_chunks = drop_chunks + 32'd1;
                drop_bytes  = drop_bytes + len[31:0] + 32'd12;
              end
              left  = len[32:0] + 33'd4;
              phase = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (keep_chunk) push_byte(b);
          pos = pos + 32'd1;
          if (left != 33'd0) left = left - 33'd1;
          if (left == 33'd0) begin
            if (end_chunk) push_report(ST_OK);
            else chunk_boundary();
          end
        end
        default: ;
      endcase
      if (expected_words.size() > first)
        expected_words[expected_words.size() - 1].run_end = 1'b1;
    endfunction

    // Accepted output word: compare with the oldest expectation
    function void check_word(result_word_t got);
      result_word_t want;
      checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word with nothing expected: kind=%0d byte=%02h status=%0d chunks=%0d bytes=%0d last=%0d",
                   got.kind, got.byte_val, got.stat, got.rm_chunks, got.rm_bytes, got.run_end);
        return;
      end
      want = expected_words.pop_front();
      if (got.kind !== want.kind || got.byte_val !== want.byte_val ||
          got.stat !== want.stat || got.rm_chunks !== want.rm_chunks ||
          got.rm_bytes !== want.rm_bytes || got.run_end !== want.run_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: word %0d expected kind=%0d byte=%02h status=%0d chunks=%0d bytes=%0d last=%0d",
                   checked, want.kind, want.byte_val, want.stat, want.rm_chunks,
                   want.rm_bytes, want.run_end);
          $display("ERROR: word %0d actual   kind=%0d byte=%02h status=%0d chunks=%0d bytes=%0d last=%0d",
                   checked, got.kind, got.byte_val, got.stat, got.rm_chunks,
                   got.rm_bytes, got.run_end);
        end
      end
    endfunction
  endclass

endpackage

[test/tb_png_metadata_chunk_filter_unit.sv]
// Testbench for png_metadata_chunk_filter_unit: streams a PNG-shaped file
// with random chunks, moves the file length around, checks every output word.
// Depends on pmcf_pkg and png_chunk_filter_scoreboard_pkg.
`timescale 1ns / 100ps

module tb_png_metadata_chunk_filter_unit;
  import pmcf_pkg::*;
  import png_chunk_filter_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;

  // Ordinary chunk types that pass through
  localparam logic [31:0] CT_IHDR = 32'h4948_4452;
  localparam logic [31:0] CT_IDAT = 32'h4944_4154;
  localparam logic [31:0] CT_PLTE = 32'h504C_5445;
  localparam logic [31:0] CT_GAMA = 32'h6741_4D41;

  // How a chunk moves the file length register
  typedef enum int {
    LEN_OPEN,  // leave it alone
    LEN_FIT,   // tight around this chunk, reopened once the header is in
    LEN_STOP   // tight around this chunk and left there, walk ends
  } length_plan_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        item_kind;
  logic [7:0]  out_byte;
  logic        status;
  logic [31:0] removed_chunks;
  logic [31:0] removed_bytes;
  logic        run_last;

  chunk_filter_scoreboard sb = new();

  int unsigned cycles = 0;
  int unsigned file_pos = 0;
  int          chunks_sent = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b0;
  logic        stalls_on = 1'b0;
  string       ending_name = "";

  png_metadata_chunk_filter_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .item_kind      (item_kind),
    .out_byte       (out_byte),
    .status         (status),
    .removed_chunks (removed_chunks),
    .removed_bytes  (removed_bytes),
    .run_last       (run_last)
  );

  always #1 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] removed_type(int unsigned i);
    case (i)
      0: return TYPE_EXIF;
      1: return TYPE_TEXT;
      2: return TYPE_ITXT;
      3: return TYPE_ZTXT;
      default: return TYPE_TIME;
    endcase
  endfunction

  // Metadata, ordinary, one-bit near misses of metadata, and random types
  function automatic logic [31:0] pick_type();
    int          r;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      t = removed_type($urandom_range(0, 4));
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0: t = CT_IHDR;
        1: t = CT_IDAT;
        2: t = CT_PLTE;
        default: t = CT_GAMA;
      endcase
    end else if (r < 92) begin
      t = removed_type($urandom_range(0, 4)) ^ (32'd1 << $urandom_range(0, 31));
    end else begin
      t = $urandom;
    end
    return t;
  endfunction

  // A length far beyond anything this run streams
  function automatic logic [31:0] open_length();
    return ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : (32'h8000_0000 | $urandom);
  endfunction

  // Accepted words go to the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_byte);
      if (out_valid && out_ready)
        sb.check_word(result_word_t'{item_kind, out_byte, status, removed_chunks,
                                     removed_bytes, run_last});
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (stalls_on) stall_left <= gap_len();
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    file_pos++;
  endtask

  // Hold the input until every expected word is out, then let the tail settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_length(v);
  endtask

  // Big-endian length, then the four type bytes
  task automatic send_header(input logic [31:0] len, input logic [31:0] ctype);
    int i;
    for (i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    for (i = 3; i >= 0; i--) send_byte(ctype[8*i +: 8]);
  endtask

  task automatic send_chunk(input logic [31:0] ctype, input logic [31:0] dlen,
                            input length_plan_t plan, input int slack);
    logic [31:0] chunk_end;
    chunk_end = file_pos + 32'd12 + dlen;
    if (plan != LEN_OPEN) begin
      wait_idle();
      write_length(chunk_end + 32'(slack));
    end
    send_header(dlen, ctype);
    if (plan == LEN_FIT) begin
      wait_idle();
      write_length(open_length());
    end
    // data and CRC are arbitrary
    repeat (dlen + 4) send_byte(8'($urandom_range(0, 255)));
    chunks_sent++;
  endtask

  initial begin
    int          i;
    logic [31:0] dlen;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Both extremes of the length register while idle
    write_length(32'd0);
    wait_idle();
    write_length(32'hFFFF_FFFF);

    // Directed: clean signature, then an empty tEXt that ends exactly at
    // the file length, with the length reopened mid-chunk
    for (i = 0; i < 8; i++) send_byte(PNG_SIG[i]);
    send_chunk(TYPE_TEXT, 32'd0, LEN_FIT, 0);

    // Random chunk walk
    gaps_on = 1'b1;
    stalls_on <= 1'b1;
    while (file_pos < 320) begin
      if ($urandom_range(0, 4) == 0) gaps_on = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) stalls_on <= 1'($urandom_range(0, 1));
      dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
      if ($urandom_range(0, 5) == 0)
        send_chunk(pick_type(), dlen, LEN_FIT,
                   ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30));
      else
        send_chunk(pick_type(), dlen, LEN_OPEN, 0);
    end

    // One way of ending the walk
    dlen = $urandom_range(0, 12);
    case ($urandom_range(0, 3))
      0: begin
        ending_name = "IEND";
        send_chunk(TYPE_IEND, ($urandom_range(0, 1) == 0) ? 32'd0 : dlen, LEN_OPEN, 0);
      end
      1: begin
        ending_name = "too few bytes left";
        send_chunk(pick_type(), dlen, LEN_STOP, $urandom_range(0, 11));
      end
      2: begin
        ending_name = "chunk just past the file end";
        send_chunk(pick_type(), dlen, LEN_STOP, -int'($urandom_range(1, 12)));
      end
      default: begin
        ending_name = "chunk length of all ones";
        send_header(32'hFFFF_FFFF, pick_type());
      end
    endcase

    // Bytes after the report are swallowed
    repeat (16) send_byte(8'($urandom_range(0, 255)));

    wait_idle();
    $display("Streamed %0d bytes in %0d chunks (%0d removed, %0d removed bytes);",
             file_pos, chunks_sent, sb.drop_chunks, sb.drop_bytes);
    $display("%0d words checked, walk ended by %s; %0d mismatches.",
             sb.checked, ending_name, sb.mismatches);
    if (sb.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/pmcf_pkg.sv
design/pmcf_walk.sv
design/pmcf_emit.sv
design/png_metadata_chunk_filter_unit.sv
test/png_chunk_filter_scoreboard_pkg.sv
test/tb_png_metadata_chunk_filter_unit.sv
